// ===== rtl/dbtc_pkg.sv =====
// Shared types, codes and constants of the DRAM bank timing checker.
`default_nettype none
package dbtc_pkg;

	localparam int ROWS = 65536;
	localparam int SAME_OP_GAP = 2;
	localparam int FQ_DEPTH_DEF = 2;
	localparam int RQ_DEPTH_DEF = 2;

	typedef enum logic [3:0] {
		REQ_ACT = 4'd0,
		REQ_PRE = 4'd1,
		REQ_RD = 4'd2,
		REQ_WR = 4'd3,
		REQ_CAN_ACT = 4'd4,
		REQ_CAN_PRE = 4'd5,
		REQ_CAN_RD = 4'd6,
		REQ_CAN_WR = 4'd7,
		REQ_SET_PRIO = 4'd8,
		REQ_CLR_PRIO = 4'd9
	} req_t;

	typedef enum logic [1:0] {
		OP_PRE = 2'd0,
		OP_ACT = 2'd1,
		OP_RD = 2'd2,
		OP_WR = 2'd3
	} prio_op_t;

	typedef enum logic [2:0] {
		PEND_NONE = 3'd0,
		PEND_PRE = 3'd1,
		PEND_ACT = 3'd2,
		PEND_RD = 3'd3,
		PEND_WR = 3'd4
	} pend_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ILLEGAL = 2'd1,
		ST_ROW = 2'd2,
		ST_PRIO = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CFG_T_RP = 3'd0,
		CFG_T_RCD = 3'd1,
		CFG_T_RAS = 3'd2,
		CFG_T_RTP = 3'd3,
		CFG_T_CAS = 3'd4,
		CFG_T_CWL = 3'd5,
		CFG_T_BURST = 3'd6,
		CFG_T_WR = 3'd7
	} cfg_idx_t;

	localparam logic [9:0] T_RP_RST = 10'd15;
	localparam logic [9:0] T_RCD_RST = 10'd15;
	localparam logic [9:0] T_RAS_RST = 10'd35;
	localparam logic [9:0] T_RTP_RST = 10'd8;
	localparam logic [9:0] T_CAS_RST = 10'd15;
	localparam logic [9:0] T_CWL_RST = 10'd11;
	localparam logic [9:0] T_BURST_RST = 10'd4;
	localparam logic [9:0] T_WR_RST = 10'd15;

	typedef struct packed {
		logic [9:0] t_rp;
		logic [9:0] t_rcd;
		logic [9:0] t_ras;
		logic [9:0] t_rtp;
		logic [9:0] t_cas;
		logic [9:0] t_cwl;
		logic [9:0] t_burst;
		logic [9:0] t_wr;
	} cfg_t;

	typedef struct packed {
		logic [3:0] req_type;
		logic [15:0] row_addr;
		logic [1:0] prio_op;
		logic [31:0] now_time;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] wait_time;
		logic prio_warning;
	} out_item_t;

	// classified request as handed from front to back
	typedef struct packed {
		req_t kind;
		logic known;
		logic row_bad;
		logic [15:0] row;
		prio_op_t op;
		logic [31:0] now;
	} dec_item_t;

endpackage
`default_nettype wire

// ===== rtl/dbtc_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none
module dbtc_front #(
	parameter int FQ_DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input dbtc_pkg::in_item_t request,
	output logic deq_valid,
	input wire logic deq_ready,
	output dbtc_pkg::dec_item_t deq_item
);
	import dbtc_pkg::*;

	localparam int AW = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
	localparam int CW = $clog2(FQ_DEPTH + 1);

	dec_item_t mem_q [FQ_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	dec_item_t dec;
	logic do_push, do_pop;

	always_comb begin
		dec.kind = req_t'(request.req_type);
		dec.known = (request.req_type <= REQ_CLR_PRIO);
		dec.row_bad = ({1'b0, request.row_addr} >= 17'(ROWS));
		dec.row = request.row_addr;
		dec.op = prio_op_t'(request.prio_op);
		dec.now = request.now_time;
	end

	assign full = (count_q == CW'(FQ_DEPTH));
	assign deq_valid = (count_q != '0);
	assign deq_item = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = deq_valid && deq_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(FQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(FQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dbtc_back.sv =====
// Back end: bank state, timing checks and updates, and the result queue.
`default_nettype none
module dbtc_back #(
	parameter int RQ_DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input dbtc_pkg::cfg_t cfg,
	input wire logic in_valid,
	output logic in_ready,
	input dbtc_pkg::dec_item_t in_item,
	output logic empty,
	input wire logic pop,
	output dbtc_pkg::out_item_t result
);
	import dbtc_pkg::*;

	localparam int AW = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
	localparam int CW = $clog2(RQ_DEPTH + 1);

	typedef struct packed {
		status_t st;
		logic [33:0] w;
	} q_res_t;

	function automatic logic [31:0] remain(input logic [31:0] target, input logic [31:0] now);
		return (target > now) ? target - now : 32'd0;
	endfunction

	function automatic logic [31:0] sat32(input logic [33:0] v);
		return (v[33:32] != 2'b00) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic logic [31:0] add_sat(input logic [31:0] now, input logic [11:0] d);
		logic [32:0] s;
		s = {1'b0, now} + 33'(d);
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// bank state
	logic bank_open_q;
	logic [15:0] open_row_q;
	pend_t pending_q;
	logic [31:0] next_act_q, next_pre_q, next_rd_q, next_wr_q;

	logic bank_open_d;
	logic [15:0] open_row_d;
	pend_t pending_d;
	logic [31:0] next_act_d, next_pre_d, next_rd_d, next_wr_d;

	// result queue
	out_item_t mem_q [RQ_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	logic fire, do_pop;
	logic [31:0] now;
	logic row_hit;
	logic [31:0] rem_act, rem_pre, rem_rd, rem_wr;
	logic [10:0] sum_cb, rd_gap;
	logic [11:0] wr_full;
	q_res_t qa, qp, qr, qw, qsel;
	logic [31:0] rd_rtp, wr_rec;
	status_t st;
	logic [33:0] w;
	logic warn;
	out_item_t res;

	assign in_ready = (count_q != CW'(RQ_DEPTH));
	assign fire = in_valid && in_ready;
	assign empty = (count_q == '0);
	assign do_pop = pop && !empty;
	assign result = mem_q[rd_ptr_q];

	assign now = in_item.now;
	assign row_hit = (in_item.row == open_row_q);
	assign rem_act = remain(next_act_q, now);
	assign rem_pre = remain(next_pre_q, now);
	assign rem_rd = remain(next_rd_q, now);
	assign rem_wr = remain(next_wr_q, now);
	assign sum_cb = {1'b0, cfg.t_cas} + {1'b0, cfg.t_burst};
	assign rd_gap = (sum_cb > {1'b0, cfg.t_cwl}) ? sum_cb - {1'b0, cfg.t_cwl} : 11'd0;
	assign wr_full = {2'b00, cfg.t_cwl} + {2'b00, cfg.t_burst} + {2'b00, cfg.t_wr};
	assign rd_rtp = add_sat(now, {2'b00, cfg.t_rtp});
	assign wr_rec = add_sat(now, wr_full);

	always_comb begin
		qa.st = ST_OK;
		qa.w = {2'b00, rem_act};
		if (pending_q == PEND_PRE) begin
			qa.w = {2'b00, rem_pre} + 34'(cfg.t_rp);
		end else if (bank_open_q) begin
			qa.st = ST_ILLEGAL;
		end
	end

	always_comb begin
		qp.st = ST_OK;
		qp.w = {2'b00, rem_pre};
		if (pending_q == PEND_RD) begin
			qp.w = {2'b00, rem_rd} + 34'(cfg.t_rtp);
		end else if (pending_q == PEND_WR) begin
			qp.w = {2'b00, rem_wr} + 34'(wr_full);
		end else if (pending_q == PEND_ACT) begin
			qp.w = {2'b00, rem_act} + 34'(cfg.t_ras);
		end else if (!bank_open_q) begin
			qp.st = ST_ILLEGAL;
		end
	end

	always_comb begin
		qr.st = ST_OK;
		qr.w = {2'b00, rem_rd};
		if (in_item.row_bad) begin
			qr.st = ST_ROW;
		end else if (pending_q == PEND_RD && row_hit) begin
			qr.w = {2'b00, rem_rd} + 34'(SAME_OP_GAP);
		end else if (pending_q == PEND_WR && row_hit) begin
			qr.w = {2'b00, rem_wr} + 34'(wr_full);
		end else if (pending_q == PEND_ACT) begin
			qr.w = {2'b00, rem_act} + 34'(cfg.t_rcd);
		end else if (pending_q == PEND_PRE || !bank_open_q || !row_hit) begin
			qr.st = ST_ILLEGAL;
		end
	end

	always_comb begin
		qw.st = ST_OK;
		qw.w = {2'b00, rem_wr};
		if (in_item.row_bad) begin
			qw.st = ST_ROW;
		end else if (pending_q == PEND_RD && row_hit) begin
			qw.w = {2'b00, rem_rd} + 34'(rd_gap);
		end else if (pending_q == PEND_WR && row_hit) begin
			qw.w = {2'b00, rem_wr} + 34'(SAME_OP_GAP);
		end else if (pending_q == PEND_ACT) begin
			qw.w = {2'b00, rem_act} + 34'(cfg.t_rcd);
		end else if (pending_q == PEND_PRE || !bank_open_q || !row_hit) begin
			qw.st = ST_ILLEGAL;
		end
	end

	always_comb begin
		case (in_item.op)
			OP_PRE: qsel = qp;
			OP_ACT: qsel = qa;
			OP_RD: qsel = qr;
			OP_WR: qsel = qw;
			default: qsel = qw;
		endcase
	end

	always_comb begin
		bank_open_d = bank_open_q;
		open_row_d = open_row_q;
		pending_d = pending_q;
		next_act_d = next_act_q;
		next_pre_d = next_pre_q;
		next_rd_d = next_rd_q;
		next_wr_d = next_wr_q;
		st = ST_OK;
		w = '0;
		warn = 1'b0;
		if (!in_item.known) begin
			st = ST_ILLEGAL;
		end else begin
			case (in_item.kind)
				REQ_ACT: begin
					if (in_item.row_bad) begin
						st = ST_ROW;
					end else if (bank_open_q || next_act_q > now) begin
						st = ST_ILLEGAL;
					end else begin
						open_row_d = in_item.row;
						bank_open_d = 1'b1;
						next_rd_d = add_sat(now, {2'b00, cfg.t_rcd});
						next_wr_d = add_sat(now, {2'b00, cfg.t_rcd});
						next_pre_d = add_sat(now, {2'b00, cfg.t_ras});
						w = 34'(cfg.t_rcd);
						if (pending_q == PEND_ACT) begin
							pending_d = PEND_NONE;
						end else begin
							warn = (pending_q != PEND_NONE);
						end
					end
				end
				REQ_PRE: begin
					if (!bank_open_q || now < next_pre_q) begin
						st = ST_ILLEGAL;
					end else begin
						bank_open_d = 1'b0;
						next_act_d = add_sat(now, {2'b00, cfg.t_rp});
						w = 34'(cfg.t_rp);
						if (pending_q == PEND_PRE) begin
							pending_d = PEND_NONE;
						end else begin
							warn = (pending_q != PEND_NONE);
						end
					end
				end
				REQ_RD: begin
					if (in_item.row_bad) begin
						st = ST_ROW;
					end else if (!bank_open_q || !row_hit || now < next_rd_q) begin
						st = ST_ILLEGAL;
					end else begin
						next_wr_d = add_sat(now, {1'b0, rd_gap});
						if (rd_rtp > next_pre_q) begin
							next_pre_d = rd_rtp;
						end
						w = 34'(sum_cb);
						if (pending_q == PEND_RD) begin
							pending_d = PEND_NONE;
						end else begin
							warn = (pending_q != PEND_NONE);
						end
					end
				end
				REQ_WR: begin
					if (in_item.row_bad) begin
						st = ST_ROW;
					end else if (!bank_open_q || !row_hit || now < next_wr_q) begin
						st = ST_ILLEGAL;
					end else begin
						if (wr_rec > next_pre_q) begin
							next_pre_d = wr_rec;
						end
						w = 34'(cfg.t_cwl) + 34'(cfg.t_burst);
						if (pending_q == PEND_WR) begin
							pending_d = PEND_NONE;
						end else begin
							warn = (pending_q != PEND_NONE);
						end
					end
				end
				REQ_CAN_ACT: begin
					st = qa.st;
					w = qa.w;
				end
				REQ_CAN_PRE: begin
					st = qp.st;
					w = qp.w;
				end
				REQ_CAN_RD: begin
					st = qr.st;
					w = qr.w;
				end
				REQ_CAN_WR: begin
					st = qw.st;
					w = qw.w;
				end
				REQ_SET_PRIO: begin
					if (pending_q != PEND_NONE) begin
						st = ST_PRIO;
					end else begin
						st = qsel.st;
						w = qsel.w;
						if (qsel.st == ST_OK) begin
							case (in_item.op)
								OP_PRE: pending_d = PEND_PRE;
								OP_ACT: pending_d = PEND_ACT;
								OP_RD: pending_d = PEND_RD;
								OP_WR: pending_d = PEND_WR;
								default: pending_d = PEND_NONE;
							endcase
						end
					end
				end
				REQ_CLR_PRIO: begin
					pending_d = PEND_NONE;
				end
				default: begin
					st = ST_ILLEGAL;
				end
			endcase
		end
		res.status = st;
		res.wait_time = (st == ST_OK) ? sat32(w) : 32'd0;
		res.prio_warning = (st == ST_OK) ? warn : 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_open_q <= 1'b0;
			open_row_q <= '0;
			pending_q <= PEND_NONE;
			next_act_q <= '0;
			next_pre_q <= '0;
			next_rd_q <= '0;
			next_wr_q <= '0;
		end else if (fire) begin
			bank_open_q <= bank_open_d;
			open_row_q <= open_row_d;
			pending_q <= pending_d;
			next_act_q <= next_act_d;
			next_pre_q <= next_pre_d;
			next_rd_q <= next_rd_d;
			next_wr_q <= next_wr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (fire) begin
				wr_ptr_q <= (wr_ptr_q == AW'(RQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(RQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (fire && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!fire && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dram_bank_timing_checker_unit.sv =====
// Top level of the DRAM bank timing checker: timing registers, front and back ends.
// One item per clock sustained in both directions while results are popped and neither
// queue is full. The front end queues classified requests (FQ_DEPTH entries); the back
// end checks and updates the bank state for each item and places the result in a queue
// of RQ_DEPTH entries. With both queues empty a request is registered in the front queue
// and then in the result queue before its result shows on the result ports. The state
// update in the back end sets the rate. Timing registers are written through the cfg
// port, which is always ready.
`default_nettype none
module dram_bank_timing_checker_unit #(
	parameter int FQ_DEPTH = dbtc_pkg::FQ_DEPTH_DEF,
	parameter int RQ_DEPTH = dbtc_pkg::RQ_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input dbtc_pkg::in_item_t request,
	output logic empty,
	input wire logic pop,
	output dbtc_pkg::out_item_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [9:0] cfg_data
);
	import dbtc_pkg::*;

	cfg_t cfg_q;
	logic deq_valid, deq_ready;
	dec_item_t deq_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.t_rp <= T_RP_RST;
			cfg_q.t_rcd <= T_RCD_RST;
			cfg_q.t_ras <= T_RAS_RST;
			cfg_q.t_rtp <= T_RTP_RST;
			cfg_q.t_cas <= T_CAS_RST;
			cfg_q.t_cwl <= T_CWL_RST;
			cfg_q.t_burst <= T_BURST_RST;
			cfg_q.t_wr <= T_WR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_T_RP: cfg_q.t_rp <= cfg_data;
				CFG_T_RCD: cfg_q.t_rcd <= cfg_data;
				CFG_T_RAS: cfg_q.t_ras <= cfg_data;
				CFG_T_RTP: cfg_q.t_rtp <= cfg_data;
				CFG_T_CAS: cfg_q.t_cas <= cfg_data;
				CFG_T_CWL: cfg_q.t_cwl <= cfg_data;
				CFG_T_BURST: cfg_q.t_burst <= cfg_data;
				CFG_T_WR: cfg_q.t_wr <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	dbtc_front #(
		.FQ_DEPTH(FQ_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.request(request),
		.deq_valid(deq_valid),
		.deq_ready(deq_ready),
		.deq_item(deq_item)
	);

	dbtc_back #(
		.RQ_DEPTH(RQ_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(deq_valid),
		.in_ready(deq_ready),
		.in_item(deq_item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule
`default_nettype wire

// ===== rtl/dbtc_checker.sv =====
// Port-level assertions for the DRAM bank timing checker, bound to the top level.
`default_nettype none
module dbtc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic full,
	input wire logic empty,
	input wire logic pop,
	input dbtc_pkg::out_item_t result
);
	import dbtc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result item changed or vanished");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != ST_OK) |-> (result.wait_time == 32'd0 && !result.prio_warning))
		else $error("error result item carries wait time or warning");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && empty) |=> ##1 !empty)
		else $error("result item late on an idle block");

	a_full_backed: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("input full while no result item waits");

endmodule

bind dram_bank_timing_checker_unit dbtc_checker u_dbtc_checker (.*);
`default_nettype wire
